>>> hdl/text_tokenizer_unit_assert.svh
// ============================================================================
// Assertion macros for the text tokenizer unit
// Shared macros; all assertion text is removed when ASSERT_OFF is defined.
// ============================================================================
`ifndef TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define TEXT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TT_ASSERT(lbl, prop, msg)
`define TT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/tt_pkg.sv
// ============================================================================
// Text tokenizer package
// Types, byte codes, token kinds and byte classes shared by the tokenizer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int START_W         = 16;
  localparam int LEN_W           = 16;
  localparam int VAL_W           = 64;
  localparam int Q_DEPTH         = 4;
  localparam int Q_AW            = $clog2(Q_DEPTH);
  localparam int Q_CW            = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;

  typedef enum logic [2:0] {
    M_IDLE, M_SPACE, M_NAME, M_INT, M_STR, M_SLASH, M_CMNT, M_COLON
  } tt_mode_t;

  typedef enum logic [3:0] {
    K_EOF    = 4'd0,
    K_NAME   = 4'd1,
    K_INT    = 4'd2,
    K_STRING = 4'd3,
    K_PLUS   = 4'd4,
    K_MINUS  = 4'd5,
    K_COLON  = 4'd6,
    K_COLON2 = 4'd7,
    K_COMMA  = 4'd8,
    K_ERROR  = 4'd9
  } tt_kind_t;

  typedef struct packed {
    tt_kind_t             kind;
    logic [START_W-1:0]   start;
    logic [LEN_W-1:0]     len;
    logic [VAL_W-1:0]     value;
  } tt_tok_t;

  // The second result of a byte is always a short token with no value.
  typedef struct packed {
    tt_tok_t              first;
    logic                 two;
    tt_kind_t             sec_kind;
    logic [START_W-1:0]   sec_start;
    logic                 sec_len;
  } tt_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tt_q_stat_t;

  function automatic logic is_letter(input logic [7:0] b);
    return b inside {[CH_LOA:CH_LOZ], [CH_UPA:CH_UPZ]};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {CH_SP, CH_LF, CH_CR, CH_TAB, CH_FF, CH_VT};
  endfunction

endpackage

`default_nettype wire

>>> hdl/tt_queue.sv
// ============================================================================
// Tokenizer result queue
// Short register queue of per-byte result entries between front and back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "text_tokenizer_unit_assert.svh"

module tt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  tt_pkg::tt_entry_t      push_entry,
  input  wire logic              pop,
  output tt_pkg::tt_entry_t      head,
  output tt_pkg::tt_q_stat_t     stat
);
  import tt_pkg::*;

  tt_entry_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = Q_AW'((Q_CW'(wr_ptr_r) + Q_CW'(1)) % Q_CW'(Q_DEPTH));
    end
    if (pop) begin
      rd_ptr_nxt = Q_AW'((Q_CW'(rd_ptr_r) + Q_CW'(1)) % Q_CW'(Q_DEPTH));
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + Q_CW'(1);
      2'b01:   cnt_nxt = cnt_r - Q_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));

  `TT_ASSERT(a_no_overflow, push |-> !stat.full, "Queue written while full.")
  `TT_ASSERT(a_no_underflow, pop |-> !stat.empty, "Queue read while empty.")
  `TT_ASSERT(a_cnt_range, cnt_r <= Q_CW'(Q_DEPTH), "Queue count out of range.")

endmodule

`default_nettype wire

>>> hdl/tt_front.sv
// ============================================================================
// Tokenizer front end
// Accepts one byte per cycle while the queue is not full, runs the lexer
// state machine and queues the results caused by each byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tt_front #(
  parameter int OFFSET_BITS = tt_pkg::OFFSET_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // ch
  input  tt_pkg::tt_q_stat_t     q_stat,
  output logic                   q_push,
  output tt_pkg::tt_entry_t      q_entry
);
  import tt_pkg::*;

  tt_mode_t                   mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]     pos_r, pos_nxt;
  logic [START_W-1:0]         tstart_r, tstart_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic [VAL_W-1:0]           acc_r, acc_nxt;

  logic                       accept;
  logic [7:0]                 ch;
  logic [OFFSET_BITS-1:0]     pos_inc;
  logic [OFFSET_BITS+START_W-1:0] pos_ext, inc_ext;
  logic [START_W-1:0]         p16, p1_16;
  logic [LEN_W-1:0]           cnt_up;
  logic [7:0]                 digit;
  logic [VAL_W-1:0]           acc_mac;

  tt_mode_t                   idle_mode;
  logic                       idle_emit;
  tt_kind_t                   idle_kind;
  logic [START_W-1:0]         idle_start;
  logic                       idle_len1;
  logic                       idle_cnt_ld;
  logic [LEN_W-1:0]           idle_cnt;
  logic                       idle_acc_ld;

  logic                       end_emit;
  tt_kind_t                   end_kind;
  logic [LEN_W-1:0]           end_len;
  logic [VAL_W-1:0]           end_val;
  logic                       use_idle;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !q_stat.full;
  assign ch        = in_tdata;
  assign pos_inc   = pos_r + OFFSET_BITS'(1);
  assign pos_ext   = {{START_W{1'b0}}, pos_r};
  assign inc_ext   = {{START_W{1'b0}}, pos_inc};
  assign p16       = pos_ext[START_W-1:0];
  assign p1_16     = inc_ext[START_W-1:0];
  assign cnt_up    = (cnt_r == LEN_MAX) ? cnt_r : cnt_r + LEN_W'(1);
  assign digit     = ch - CH_ZERO;
  assign acc_mac   = {acc_r[VAL_W-4:0], 3'b000} + {acc_r[VAL_W-2:0], 1'b0}
                     + VAL_W'(digit);

  always_comb begin
    idle_mode   = M_IDLE;
    idle_emit   = 1'b0;
    idle_kind   = K_ERROR;
    idle_start  = p16;
    idle_len1   = 1'b1;
    idle_cnt_ld = 1'b0;
    idle_cnt    = '0;
    idle_acc_ld = 1'b0;
    if (ch == CH_NUL) begin
      idle_emit = 1'b1;
      idle_kind = K_EOF;
      idle_len1 = 1'b0;
    end else if (ch inside {CH_SP, CH_LF, CH_CR, CH_TAB, CH_FF}) begin
      idle_mode = M_SPACE;
    end else if (is_letter(ch) || ch == CH_UNDER) begin
      idle_mode   = M_NAME;
      idle_cnt_ld = 1'b1;
      idle_cnt    = LEN_W'(1);
    end else if (is_digit(ch)) begin
      idle_mode   = M_INT;
      idle_cnt_ld = 1'b1;
      idle_cnt    = LEN_W'(1);
      idle_acc_ld = 1'b1;
    end else if (ch == CH_QUOTE) begin
      idle_mode   = M_STR;
      idle_start  = p1_16;
      idle_cnt_ld = 1'b1;
    end else if (ch == CH_SLASH) begin
      idle_mode = M_SLASH;
    end else if (ch == CH_COLON) begin
      idle_mode = M_COLON;
    end else if (ch == CH_PLUS) begin
      idle_emit = 1'b1;
      idle_kind = K_PLUS;
    end else if (ch == CH_MINUS) begin
      idle_emit = 1'b1;
      idle_kind = K_MINUS;
    end else if (ch == CH_COMMA) begin
      idle_emit = 1'b1;
      idle_kind = K_COMMA;
    end else begin
      idle_emit = 1'b1;
      idle_kind = K_ERROR;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      case (mode_r)
        M_SPACE: mode_nxt = is_space(ch) ? M_SPACE : idle_mode;
        M_NAME:  mode_nxt = (is_letter(ch) || ch == CH_UNDER) ? M_NAME : idle_mode;
        M_INT:   mode_nxt = (is_letter(ch) || is_digit(ch)) ? M_INT : idle_mode;
        M_STR: begin
          if (ch == CH_QUOTE) begin
            mode_nxt = M_IDLE;
          end else if (ch == CH_NUL) begin
            mode_nxt = idle_mode;
          end else begin
            mode_nxt = M_STR;
          end
        end
        M_SLASH: mode_nxt = (ch == CH_SLASH) ? M_CMNT : idle_mode;
        M_CMNT: begin
          if (ch == CH_LF) begin
            mode_nxt = M_SPACE;
          end else if (ch == CH_NUL) begin
            mode_nxt = idle_mode;
          end else begin
            mode_nxt = M_CMNT;
          end
        end
        M_COLON: mode_nxt = (ch == CH_COLON) ? M_IDLE : idle_mode;
        default: mode_nxt = idle_mode;
      endcase
    end
  end

  always_comb begin
    end_emit   = 1'b0;
    end_kind   = K_ERROR;
    end_len    = cnt_r;
    end_val    = '0;
    use_idle   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    case (mode_r)
      M_SPACE: use_idle = !is_space(ch);
      M_NAME: begin
        if (is_letter(ch) || ch == CH_UNDER) begin
          cnt_nxt = cnt_up;
        end else begin
          end_emit = 1'b1;
          end_kind = K_NAME;
          use_idle = 1'b1;
        end
      end
      M_INT: begin
        if (is_letter(ch) || is_digit(ch)) begin
          acc_nxt = acc_mac;
          cnt_nxt = cnt_up;
        end else begin
          end_emit = 1'b1;
          end_kind = K_INT;
          end_val  = acc_r;
          acc_nxt  = '0;
          use_idle = 1'b1;
        end
      end
      M_STR: begin
        if (ch == CH_QUOTE) begin
          end_emit = 1'b1;
          end_kind = K_STRING;
        end else if (ch == CH_NUL) begin
          end_emit = 1'b1;
          end_kind = K_ERROR;
          use_idle = 1'b1;
        end else begin
          cnt_nxt = cnt_up;
        end
      end
      M_SLASH: begin
        if (ch != CH_SLASH) begin
          end_emit = 1'b1;
          end_kind = K_ERROR;
          end_len  = LEN_W'(1);
          use_idle = 1'b1;
        end
      end
      M_CMNT: use_idle = (ch == CH_NUL);
      M_COLON: begin
        end_emit = 1'b1;
        use_idle = (ch != CH_COLON);
        end_kind = (ch == CH_COLON) ? K_COLON2 : K_COLON;
        end_len  = (ch == CH_COLON) ? LEN_W'(2) : LEN_W'(1);
      end
      default: use_idle = 1'b1;
    endcase

    tstart_nxt = tstart_r;
    if (use_idle) begin
      tstart_nxt = idle_start;
      if (idle_cnt_ld) begin
        cnt_nxt = idle_cnt;
      end
      if (idle_acc_ld) begin
        acc_nxt = VAL_W'(digit);
      end
    end
    pos_nxt = pos_inc;

    q_push  = accept && (end_emit || (use_idle && idle_emit));
    q_entry.two       = end_emit && use_idle && idle_emit;
    q_entry.sec_kind  = idle_kind;
    q_entry.sec_start = p16;
    q_entry.sec_len   = idle_len1;
    if (end_emit) begin
      q_entry.first.kind  = end_kind;
      q_entry.first.start = tstart_r;
      q_entry.first.len   = end_len;
      q_entry.first.value = end_val;
    end else begin
      q_entry.first.kind  = idle_kind;
      q_entry.first.start = p16;
      q_entry.first.len   = LEN_W'(idle_len1);
      q_entry.first.value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      cnt_r    <= '0;
      acc_r    <= '0;
    end else begin
      mode_r <= mode_nxt;
      if (accept) begin
        pos_r    <= pos_nxt;
        tstart_r <= tstart_nxt;
        cnt_r    <= cnt_nxt;
        acc_r    <= acc_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tt_back.sv
// ============================================================================
// Tokenizer back end
// Takes queued entries apart into single results and drives the output
// register of the result stream.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "text_tokenizer_unit_assert.svh"

module tt_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  tt_pkg::tt_entry_t      head,
  input  tt_pkg::tt_q_stat_t     q_stat,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [103:0]           out_tdata,  // kind, start_offset, length, int_value
  output logic                   out_tlast
);
  import tt_pkg::*;

  logic      sub_r, sub_nxt;
  logic      vld_r, vld_nxt;
  tt_tok_t   tok_r, tok_nxt;
  logic      last_r, last_nxt;
  logic      load;

  assign load = !vld_r || out_tready;

  always_comb begin
    sub_nxt  = sub_r;
    vld_nxt  = vld_r;
    tok_nxt  = tok_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    if (load) begin
      vld_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (sub_r) begin
          tok_nxt.kind  = head.sec_kind;
          tok_nxt.start = head.sec_start;
          tok_nxt.len   = LEN_W'(head.sec_len);
          tok_nxt.value = '0;
          last_nxt      = 1'b1;
          sub_nxt       = 1'b0;
          q_pop         = 1'b1;
        end else begin
          tok_nxt  = head.first;
          last_nxt = !head.two;
          sub_nxt  = head.two;
          q_pop    = !head.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'b0000, tok_r.value, tok_r.len, tok_r.start, tok_r.kind};

  `TT_ASSERT(a_sub_pair, sub_r |-> (!q_stat.empty && head.two), "Second result without a pair.")

endmodule

`default_nettype wire

>>> hdl/text_tokenizer_unit.sv
// ============================================================================
// Text tokenizer unit
// Streaming lexer that turns a byte stream into name, integer, string,
// punctuation, end-of-text and error tokens.
// ============================================================================
// The unit takes one text byte per cycle; a result is written to the queue
// with the byte that completes it and then loaded into the output register.
// Most bytes give at most one result; a byte that closes a name, integer,
// colon or lone slash and also forms a token of its own, or an end of text
// inside an open string, gives two, and the output register sends those one
// after the other, so a stream rich in such pairs is limited by the result
// side while a four-entry queue absorbs bursts. The input stalls only while
// that queue is full. The per-byte path is set by the integer accumulator,
// which folds in one digit a cycle with a 64-bit multiply by ten and add.
`timescale 1ns / 1ps
`default_nettype none

module text_tokenizer_unit #(
  parameter int OFFSET_BITS = tt_pkg::OFFSET_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // ch
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [103:0]        out_tdata,  // kind, start_offset, length, int_value
  output logic                out_tlast   // last
);
  import tt_pkg::*;

  tt_entry_t   q_entry;
  tt_entry_t   q_head;
  tt_q_stat_t  q_stat;
  logic        q_push;
  logic        q_pop;

  tt_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  tt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  tt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
